FILE: sv/rmnh_pkg.sv
package rmnh_pkg;

	localparam int MaxNodes = 32;
	localparam int NodeW = $clog2(MaxNodes);
	localparam int CountW = NodeW + 1;
	localparam int RowW = 2 * MaxNodes;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_ROUTE = 2'd1;
	localparam logic [1:0] OP_PCOUNT = 2'd2;
	localparam logic [1:0] OP_PRANK = 2'd3;

	localparam logic [1:0] REL_NONE = 2'd0;
	localparam logic [1:0] REL_PARENT = 2'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the input item
		logic write_rel;  // write the captured matrix entry
		logic clr_search; // clear visited flags, push the target
		logic rd_top;     // read the row of the current stack top
		logic step_col;   // examine one column of the latched row
		logic pop;        // pop the stack top
		logic rd_src;     // read the queried row for parent ops
		logic done;       // emit the result
	} rmnh_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] op;
		logic       src_ok;     // source (and target for routes) present
		logic       stack_empty;
		logic       last_col;   // current column is the last to examine
		logic       hit;        // source linked from the top row
		logic       pushed;     // the scan of this row pushed a node
	} rmnh_sts_t;

endpackage

FILE: sv/rmnh_ctrl.sv
module rmnh_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rmnh_pkg::rmnh_sts_t sts,
	output rmnh_pkg::rmnh_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC = 3'd1;
	localparam logic [2:0] S_RD = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_PRD = 3'd4;
	localparam logic [2:0] S_PSCAN = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.op == rmnh_pkg::OP_WRITE) begin
					cmd.write_rel = 1'b1;
					state_d = S_DONE;
				end else if (!sts.src_ok) begin
					state_d = S_DONE;
				end else if (sts.op == rmnh_pkg::OP_ROUTE) begin
					cmd.clr_search = 1'b1;
					state_d = S_RD;
				end else begin
					cmd.rd_src = 1'b1;
					state_d = S_PRD;
				end
			end
			S_RD: begin
				if (sts.stack_empty) begin
					state_d = S_DONE;
				end else begin
					cmd.rd_top = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.step_col = 1'b1;
				if (sts.hit) begin
					state_d = S_DONE;
				end else if (sts.last_col) begin
					cmd.pop = !sts.pushed;
					state_d = S_RD;
				end
			end
			S_PRD: begin
				state_d = S_PSCAN;
			end
			S_PSCAN: begin
				cmd.step_col = 1'b1;
				if (sts.last_col) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.done = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/rmnh_dp.sv
module rmnh_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  rmnh_pkg::rmnh_cmd_t                    cmd,
	output rmnh_pkg::rmnh_sts_t                    sts,
	input  logic [rmnh_pkg::CountW-1:0]            node_count,
	input  logic [1:0]                             op,
	input  logic [4:0]                             row_index,
	input  logic [4:0]                             col_index,
	input  logic [1:0]                             relation_code,
	input  logic [4:0]                             source_node,
	input  logic [4:0]                             target_node,
	input  logic [4:0]                             parent_rank,
	output logic                                   result_valid,
	output logic                                   found,
	output logic [4:0]                             hop_node,
	output logic [5:0]                             parent_total
);

	localparam int NW = rmnh_pkg::NodeW;
	localparam int CW = rmnh_pkg::CountW;
	localparam int MN = rmnh_pkg::MaxNodes;

	// Matrix rows as a memory: one write port, one registered read port.
	logic [rmnh_pkg::RowW-1:0] mem [MN];
	logic [MN-1:0]             row_valid_q;
	logic [rmnh_pkg::RowW-1:0] rd_q;
	logic                      rd_valid_q;
	logic [NW-1:0]             stack [MN];

	logic [1:0]    op_q;
	logic [4:0]    row_q, col_q, src_q, dst_q, rank_q;
	logic [1:0]    code_q;
	logic [CW-1:0] cnt_q;
	logic [MN-1:0] visited_q;
	logic [CW-1:0] depth_q;
	logic [NW-1:0] top_q;
	logic [CW-1:0] col_cnt_q;
	logic          pushed_q;
	logic          found_q;
	logic [NW-1:0] hop_q;
	logic [5:0]    total_q;
	logic [5:0]    seen_q;
	logic          rvalid_q;

	logic [NW-1:0] col;
	logic [1:0]    entry;
	logic [CW-1:0] rd_addr_w;
	logic [NW-1:0] rd_addr;
	logic          do_rd;
	logic [rmnh_pkg::RowW-1:0] row_w, row_cur;
	logic          can_push;

	assign col = col_cnt_q[NW-1:0];
	assign row_cur = rd_valid_q ? rd_q : '0;
	assign entry = row_cur[2*col +: 2];

	always_comb begin
		rd_addr_w = '0;
		if (cmd.rd_top) rd_addr_w = {1'b0, stack[depth_q[NW-1:0] - NW'(1)]};
		else rd_addr_w = {1'b0, src_q[NW-1:0]};
	end
	assign rd_addr = rd_addr_w[NW-1:0];
	assign do_rd = cmd.rd_top || cmd.rd_src;

	always_comb begin
		row_w = row_valid_q[row_q[NW-1:0]] ? mem[row_q[NW-1:0]] : '0;
		row_w[2*col_q[NW-1:0] +: 2] = code_q;
	end

	// Write merge reads the row combinationally; the matrix is 2 Kbit so
	// the row buffer is kept in flops with a per-row valid bit.
	always_ff @(posedge clk) begin
		if (cmd.write_rel) mem[row_q[NW-1:0]] <= row_w;
		if (do_rd) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.write_rel) row_valid_q[row_q[NW-1:0]] <= 1'b1;
			if (do_rd) rd_valid_q <= row_valid_q[rd_addr];
		end
	end

	logic [CW-1:0] eff;
	assign eff = (node_count > CW'(MN)) ? CW'(MN) : node_count;

	assign can_push = (entry != rmnh_pkg::REL_NONE) && !visited_q[col]
		&& (depth_q < CW'(MN));

	assign sts.op = op_q;
	assign sts.src_ok = ({1'b0, src_q} < eff) &&
		((op_q != rmnh_pkg::OP_ROUTE) || ({1'b0, dst_q} < eff));
	assign sts.stack_empty = (depth_q == '0);
	assign sts.last_col = (op_q == rmnh_pkg::OP_ROUTE) ?
		(col_cnt_q + CW'(1) >= cnt_q) : (col_cnt_q == CW'(MN - 1));
	assign sts.hit = (op_q == rmnh_pkg::OP_ROUTE) && (cnt_q != '0) &&
		(entry != rmnh_pkg::REL_NONE) && (col == src_q[NW-1:0]);
	assign sts.pushed = pushed_q || can_push;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			row_q <= row_index;
			col_q <= col_index;
			code_q <= relation_code;
			src_q <= source_node;
			dst_q <= target_node;
			rank_q <= parent_rank;
			cnt_q <= eff;
		end
		if (cmd.clr_search) stack[0] <= dst_q[NW-1:0];
		else if (cmd.step_col && op_q == rmnh_pkg::OP_ROUTE && can_push && !sts.hit)
			stack[depth_q[NW-1:0]] <= col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			depth_q <= '0;
			col_cnt_q <= '0;
			pushed_q <= 1'b0;
			found_q <= 1'b0;
			hop_q <= '0;
			total_q <= '0;
			seen_q <= '0;
			rvalid_q <= 1'b0;
			top_q <= '0;
		end else begin
			rvalid_q <= cmd.done;
			if (cmd.load) begin
				found_q <= 1'b0;
				hop_q <= '0;
				total_q <= '0;
				seen_q <= '0;
				depth_q <= '0;
			end
			if (cmd.clr_search) begin
				visited_q <= MN'(1) << dst_q[NW-1:0];
				depth_q <= CW'(1);
			end
			if (cmd.rd_top) begin
				top_q <= stack[depth_q[NW-1:0] - NW'(1)];
				col_cnt_q <= '0;
				pushed_q <= 1'b0;
			end
			if (cmd.rd_src) col_cnt_q <= '0;
			if (cmd.step_col) begin
				col_cnt_q <= col_cnt_q + CW'(1);
				if (op_q == rmnh_pkg::OP_ROUTE) begin
					if (sts.hit) begin
						found_q <= 1'b1;
						hop_q <= top_q;
					end else if (can_push) begin
						visited_q[col] <= 1'b1;
						depth_q <= depth_q + CW'(1);
						pushed_q <= 1'b1;
					end
				end else if (entry == rmnh_pkg::REL_PARENT) begin
					total_q <= total_q + 6'd1;
					seen_q <= seen_q + 6'd1;
					if (op_q == rmnh_pkg::OP_PRANK && !found_q &&
						seen_q == {1'b0, rank_q}) begin
						found_q <= 1'b1;
						hop_q <= col;
					end
				end
			end
			if (cmd.pop) depth_q <= depth_q - CW'(1);
		end
	end

	assign result_valid = rvalid_q;
	assign found = found_q;
	assign hop_node = 5'(hop_q);
	assign parent_total = total_q;

endmodule

FILE: sv/relation_matrix_next_hop_finder_core.sv
// A relation write passes from start through decode to the result strobe; a parent
// query reads the queried row and then scans all MAX_NODES columns; a route query
// reads the row of each stack top and scans it at one column per cycle up to node_count.
// Throughput: one transaction at a time; busy stays high until the result strobe.
// Reset (arst_n low) clears the relation matrix, node_count and all control state.
// The result is shown for one cycle with result_valid; the receiver cannot stall.
module relation_matrix_next_hop_finder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [4:0]  row_index,
	input  logic [4:0]  col_index,
	input  logic [1:0]  relation_code,
	input  logic [4:0]  source_node,
	input  logic [4:0]  target_node,
	input  logic [4:0]  parent_rank,
	output logic        result_valid,
	output logic        found,
	output logic [4:0]  hop_node,
	output logic [5:0]  parent_total
);

	localparam logic [1:0] ADDR_NODE_COUNT = 2'd0;

	logic [5:0] node_count_q;
	rmnh_pkg::rmnh_cmd_t cmd;
	rmnh_pkg::rmnh_sts_t sts;

	// The only register is node_count at byte address zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (psel && penable && pwrite && paddr == ADDR_NODE_COUNT) begin
			node_count_q <= pwdata[5:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_NODE_COUNT) ? {26'd0, node_count_q} : 32'd0;

	// The controller sequences each transaction; the datapath holds the matrix,
	// the search stack and the visited flags.
	rmnh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sts(sts), .cmd(cmd)
	);

	rmnh_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.node_count(node_count_q), .op(op), .row_index(row_index),
		.col_index(col_index), .relation_code(relation_code),
		.source_node(source_node), .target_node(target_node),
		.parent_rank(parent_rank), .result_valid(result_valid),
		.found(found), .hop_node(hop_node), .parent_total(parent_total)
	);

endmodule

FILE: sv/rmnh_checker.sv
module rmnh_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       result_valid,
	input logic       found,
	input logic [4:0] hop_node
);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	a_strobe_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("strobe longer than one cycle");
	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("busy with result");
	a_hop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !found |-> hop_node == 5'd0) else $error("hop without found");

endmodule

bind relation_matrix_next_hop_finder_core rmnh_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.result_valid(result_valid), .found(found), .hop_node(hop_node)
);
